@@ rtl/sws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the sector wind estimator
// Field widths, sector arithmetic constants, register map and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int unsigned HEADING_W = 9;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned DIR_W     = 9;

	localparam int unsigned SECTORS = 16;
	localparam int unsigned SEC_W   = $clog2(SECTORS);

	// sector = (4*h + 45) / 90, done as a multiply by ceil(2^20 / 90)
	localparam int unsigned SECT_NUM_W   = HEADING_W + 3;
	localparam int unsigned SECT_RECIP   = 11651;
	localparam int unsigned SECT_RECIP_W = 14;
	localparam int unsigned SECT_SHIFT   = 20;
	localparam int unsigned SECT_PROD_W  = SECT_NUM_W + SECT_RECIP_W;
	localparam int unsigned SECT_BIAS    = 45;

	// direction = (90*index + 45) / 4
	localparam int unsigned DIR_STEP  = 90;
	localparam int unsigned DIR_BIAS  = 45;
	localparam int unsigned DIR_SUM_W = DIR_W + 2;
	localparam int unsigned DIR_LIMIT = 360;

	// opposite sector offset
	localparam int unsigned HALF_TURN = SECTORS / 2;

	// configuration port
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned PADDR_W    = 3;
	localparam logic [0:0]  REG_STALE_LIMIT = 1'b0;
	localparam logic [TIME_W-1:0] STALE_RESET = 32'd300000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_AGE,
		OP_WRITE,
		OP_SCAN,
		OP_AGE_HI,
		OP_AGE_LO,
		OP_EVAL,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic             load;
		op_t              op;
		logic [SEC_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ rtl/sws_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_if: request and result channels of the sector wind estimator
// Valid/ready channels carrying one GPS sample and one wind estimate.
// ----------------------------------------------------------------------------
interface sws_sample_if;
	import sws_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [HEADING_W-1:0] heading_deg;
	logic [SPEED_W-1:0]   ground_speed;
	logic [TIME_W-1:0]    time_ms;

	modport source (output valid, output heading_deg, output ground_speed,
		output time_ms, input ready);
	modport sink (input valid, input heading_deg, input ground_speed,
		input time_ms, output ready);
endinterface

interface sws_wind_if;
	import sws_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] wind_speed;
	logic [DIR_W-1:0]   wind_direction_deg;
	logic               wind_valid;
	logic               wind_updated;

	modport source (output valid, output wind_speed, output wind_direction_deg,
		output wind_valid, output wind_updated, input ready);
	modport sink (input valid, input wind_speed, input wind_direction_deg,
		input wind_valid, input wind_updated, output ready);
endinterface

@@ rtl/sws_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ctrl: sequencer of the sector wind estimator
// Steps one request through update, sector scan, age checks and result.
// ----------------------------------------------------------------------------
module sws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output sws_pkg::cmd_t cmd,
	input  sws_pkg::sts_t sts
);
	import sws_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AGE,
		S_WRITE,
		S_SCAN,
		S_AGE_HI,
		S_AGE_LO,
		S_EVAL,
		S_EMIT
	} state_t;

	localparam logic [SEC_W-1:0] LAST_IDX = SEC_W'(SECTORS - 1);

	state_t           state_q;
	logic [SEC_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_AGE;
				end
				S_AGE:   state_q <= S_WRITE;
				S_WRITE: begin
					state_q <= S_SCAN;
					idx_q   <= '0;
				end
				S_SCAN: begin
					if (idx_q == LAST_IDX) state_q <= S_AGE_HI;
					else idx_q <= idx_q + 1'b1;
				end
				S_AGE_HI: state_q <= S_AGE_LO;
				S_AGE_LO: state_q <= S_EVAL;
				S_EVAL:   state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.idx  = idx_q;
		unique case (state_q)
			S_AGE:    cmd.op = OP_AGE;
			S_WRITE:  cmd.op = OP_WRITE;
			S_SCAN:   cmd.op = OP_SCAN;
			S_AGE_HI: cmd.op = OP_AGE_HI;
			S_AGE_LO: cmd.op = OP_AGE_LO;
			S_EVAL:   cmd.op = OP_EVAL;
			S_EMIT:   cmd.op = sts.out_free ? OP_EMIT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ rtl/sws_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_dp: datapath of the sector wind estimator
// Sector table, single read port, extreme search, wind registers and
// the result register.
// ----------------------------------------------------------------------------
module sws_dp #(
	parameter int unsigned SPEED_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sws_pkg::cmd_t                  cmd,
	output sws_pkg::sts_t                  sts,
	input  logic [sws_pkg::TIME_W-1:0]     stale_limit,
	input  logic [sws_pkg::HEADING_W-1:0]  heading_deg,
	input  logic [sws_pkg::SPEED_W-1:0]    ground_speed,
	input  logic [sws_pkg::TIME_W-1:0]     time_ms,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [sws_pkg::SPEED_W-1:0]    wind_speed,
	output logic [sws_pkg::DIR_W-1:0]      wind_direction_deg,
	output logic                           wind_valid,
	output logic                           wind_updated
);
	import sws_pkg::*;

	typedef logic [SPEED_BITS-1:0] spd_t;

	// sector table, cleared by reset
	spd_t              spd_mem_q [SECTORS];
	logic [TIME_W-1:0] tim_mem_q [SECTORS];

	// request registers
	logic [SEC_W-1:0]  sec_q;
	spd_t              spd_q;
	logic [TIME_W-1:0] now_q;

	// working registers
	logic [TIME_W-1:0] age_q;
	spd_t              old_q;
	logic [SEC_W-1:0]  hi_q, lo_q;
	spd_t              hi_spd_q, lo_spd_q;
	logic              found_q;
	logic              hi_stale_q;

	// wind state and result register
	spd_t              wind_spd_q;
	logic [DIR_W-1:0]  wind_dir_q;
	logic              upd_q;
	logic              out_valid_q;
	logic [SPEED_W-1:0] out_spd_q;
	logic [DIR_W-1:0]  out_dir_q;
	logic              out_wv_q;
	logic              out_upd_q;

	logic [SECT_NUM_W-1:0]  sect_num;
	logic [SECT_PROD_W-1:0] sect_prod;
	logic [SEC_W-1:0]       sector;
	logic [SEC_W-1:0]       rd_idx;
	spd_t                   rd_spd;
	logic [TIME_W-1:0]      rd_tim;
	logic [TIME_W-1:0]      rd_age;
	logic [SPEED_BITS:0]    avg_sum;
	logic                   fresh;
	logic [SEC_W-1:0]       opp_diff;
	logic                   opposite;
	logic                   est_ok;
	logic [DIR_SUM_W-1:0]   dir_sum;

	// sector of the incoming heading, exact for every 9-bit heading
	always_comb begin
		sect_num  = {heading_deg, 2'b00} + SECT_NUM_W'(SECT_BIAS);
		sect_prod = SECT_PROD_W'(sect_num) * SECT_PROD_W'(SECT_RECIP);
		sector    = sect_prod[SECT_SHIFT +: SEC_W];
	end

	always_comb begin
		unique case (cmd.op)
			OP_SCAN:   rd_idx = cmd.idx;
			OP_AGE_HI: rd_idx = hi_q;
			OP_AGE_LO: rd_idx = lo_q;
			default:   rd_idx = sec_q;
		endcase
		rd_spd = spd_mem_q[rd_idx];
		rd_tim = tim_mem_q[rd_idx];
		rd_age = now_q - rd_tim;
	end

	assign avg_sum = {1'b0, old_q} + {1'b0, spd_q};
	assign fresh   = (age_q < stale_limit) && (old_q != '0);

	// hi must be within one sector of lo + half a turn
	assign opp_diff = hi_q - lo_q - SEC_W'(HALF_TURN);
	assign opposite = (opp_diff == '0) || (opp_diff == SEC_W'(1)) ||
		(opp_diff == SEC_W'(SECTORS - 1));
	assign est_ok   = found_q && !hi_stale_q && !(age_q > stale_limit) && opposite;
	assign dir_sum  = DIR_SUM_W'(hi_q) * DIR_SUM_W'(DIR_STEP) + DIR_SUM_W'(DIR_BIAS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sec_q <= sector;
			spd_q <= SPEED_BITS'(ground_speed);
			now_q <= time_ms;
		end
		unique case (cmd.op)
			OP_AGE: begin
				age_q <= rd_age;
				old_q <= rd_spd;
			end
			OP_SCAN: begin
				if (cmd.idx == '0) begin
					hi_q     <= '0;
					hi_spd_q <= rd_spd;
					lo_q     <= '0;
					lo_spd_q <= rd_spd;
					found_q  <= (rd_spd != '0);
				end else begin
					if (rd_spd > hi_spd_q) begin
						hi_q     <= cmd.idx;
						hi_spd_q <= rd_spd;
					end
					if ((rd_spd != '0) && (!found_q || rd_spd < lo_spd_q)) begin
						lo_q     <= cmd.idx;
						lo_spd_q <= rd_spd;
						found_q  <= 1'b1;
					end
				end
			end
			OP_AGE_HI: age_q <= rd_age;
			OP_AGE_LO: begin
				hi_stale_q <= (age_q > stale_limit);
				age_q      <= rd_age;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_mem_q <= '{default: '0};
			tim_mem_q <= '{default: '0};
		end else if (cmd.op == OP_WRITE) begin
			spd_mem_q[sec_q] <= fresh ? avg_sum[SPEED_BITS:1] : spd_q;
			tim_mem_q[sec_q] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_spd_q <= '0;
			wind_dir_q <= '0;
			upd_q      <= 1'b0;
		end else if (cmd.op == OP_EVAL) begin
			upd_q <= est_ok;
			if (est_ok) begin
				wind_spd_q <= hi_spd_q - lo_spd_q;
				wind_dir_q <= dir_sum[DIR_SUM_W-1:2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_spd_q <= SPEED_W'(wind_spd_q);
			out_dir_q <= wind_dir_q;
			out_wv_q  <= (wind_spd_q != '0) || (wind_dir_q != '0);
			out_upd_q <= upd_q;
		end
	end

	assign sts.out_free       = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign wind_speed         = out_spd_q;
	assign wind_direction_deg = out_dir_q;
	assign wind_valid         = out_wv_q;
	assign wind_updated       = out_upd_q;

endmodule

@@ rtl/sector_wind_estimator.sv @@
`timescale 1ns / 1ps
// Each request carries one GPS fix (heading, ground speed, millisecond time)
// and yields exactly one result with the current wind estimate. A request is
// accepted, its heading's sector is read and updated, the sector table is
// scanned through its single read port for the fastest and the slowest
// nonzero sector, their ages are read, the estimate is evaluated and the
// result register is loaded; only then is the next request accepted. While a
// result waits to be taken the block goes on and accepts the next request,
// and holds that one at its last step until the result register frees up.
// The stale limit register sits at byte address 0 of the APB port, resets to
// 300000 ms and should only be written while no request is in flight.
// ----------------------------------------------------------------------------
// sector_wind_estimator: wind estimate from GPS heading and ground speed
// Top level: APB register, sequencer and sector datapath.
// ----------------------------------------------------------------------------
module sector_wind_estimator #(
	parameter int unsigned SPEED_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sws_sample_if.sink                        sample,
	sws_wind_if.source                        wind,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sws_pkg::PADDR_W-1:0]       paddr,
	input  logic [sws_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [sws_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import sws_pkg::*;

	logic [TIME_W-1:0] stale_limit_q;
	logic              reg_sel;
	logic              reg_wr;
	cmd_t              cmd;
	sts_t              sts;

	// register index is the word address; byte lanes are ignored
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_STALE_LIMIT);
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= STALE_RESET;
		end else if (reg_wr) begin
			stale_limit_q <= TIME_W'(pwdata);
		end
	end

	// reads outside the map return zero
	assign prdata = reg_sel ? APB_DATA_W'(stale_limit_q) : '0;

	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sws_dp #(
		.SPEED_BITS (SPEED_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.stale_limit        (stale_limit_q),
		.heading_deg        (sample.heading_deg),
		.ground_speed       (sample.ground_speed),
		.time_ms            (sample.time_ms),
		.out_ready          (wind.ready),
		.out_valid          (wind.valid),
		.wind_speed         (wind.wind_speed),
		.wind_direction_deg (wind.wind_direction_deg),
		.wind_valid         (wind.wind_valid),
		.wind_updated       (wind.wind_updated)
	);

endmodule

@@ rtl/sws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_checker: port-level checks of the sector wind estimator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module sws_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [sws_pkg::SPEED_W-1:0]  wind_speed,
	input logic [sws_pkg::DIR_W-1:0]    wind_direction_deg,
	input logic                         wind_valid,
	input logic                         wind_updated
);
	import sws_pkg::*;

	// a request is worked on alone: no second request right behind it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wind_speed) &&
		$stable(wind_direction_deg) && $stable(wind_valid) && $stable(wind_updated))
		else $error("result changed while stalled");

	// valid flag tracks the estimate contents
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wind_valid == ((wind_speed != '0) || (wind_direction_deg != '0)))
		else $error("wind_valid inconsistent with estimate");

	// direction stays on the compass
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wind_direction_deg < DIR_W'(DIR_LIMIT))
		else $error("wind direction out of range");

endmodule

bind sector_wind_estimator sws_checker u_sws_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (sample.valid),
	.in_ready           (sample.ready),
	.out_valid          (wind.valid),
	.out_ready          (wind.ready),
	.wind_speed         (wind.wind_speed),
	.wind_direction_deg (wind.wind_direction_deg),
	.wind_valid         (wind.wind_valid),
	.wind_updated       (wind.wind_updated)
);
